// File: src/ftlb_pkg.sv
// Shared types and constants for the FIFO translation buffer.
// Used by ftlb_match and fifo_tlb; no dependencies.
package ftlb_pkg;

    localparam int TLB_ENTRIES = 16;
    localparam int FRAME_COUNT = 4096;

    localparam int PID_W   = 16;
    localparam int PAGE_W  = 16;
    localparam int FRAME_W = 12;
    localparam int CTR_W   = 32;
    localparam int SIZE_W  = 5;
    localparam int IDX_W   = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
    localparam int CNT_W   = $clog2(TLB_ENTRIES + 1);

    // register indexes on the configuration port
    localparam logic REG_ENABLE = 1'b0;
    localparam logic REG_SIZE   = 1'b1;

    typedef enum logic [1:0] {
        OP_LOOKUP     = 2'd0,
        OP_INSERT     = 2'd1,
        OP_INVALIDATE = 2'd2
    } op_t;

    typedef struct packed {
        logic [PID_W-1:0]   pid;
        logic [PAGE_W-1:0]  page;
        logic [FRAME_W-1:0] frame;
    } entry_t;

    // search result: one-hot first match among valid slots
    typedef struct packed {
        logic                   hit;
        logic [TLB_ENTRIES-1:0] first;
        logic [FRAME_W-1:0]     frame;
    } match_t;

endpackage

// File: src/ftlb_match.sv
// Associative search over all slots of the translation buffer.
// Depends on ftlb_pkg for entry and match types.
module ftlb_match (
    input  ftlb_pkg::entry_t                     entries [ftlb_pkg::TLB_ENTRIES],
    input  logic [ftlb_pkg::CNT_W-1:0]           count,
    input  logic [ftlb_pkg::PID_W-1:0]           pid,
    input  logic [ftlb_pkg::PAGE_W-1:0]          page,
    output ftlb_pkg::match_t                     result
);
    import ftlb_pkg::*;

    logic [TLB_ENTRIES-1:0] match_vec;
    logic [TLB_ENTRIES-1:0] first_vec;
    logic [FRAME_W-1:0]     frame_sel;

    always_comb begin
        for (int i = 0; i < TLB_ENTRIES; i++) begin
            match_vec[i] = (CNT_W'(i) < count) && (entries[i].pid == pid)
                           && (entries[i].page == page);
        end
    end

    // isolate lowest set bit: oldest matching slot
    assign first_vec = match_vec & (~match_vec + TLB_ENTRIES'(1));

    always_comb begin
        frame_sel = '0;
        for (int i = 0; i < TLB_ENTRIES; i++) begin
            frame_sel = frame_sel | (entries[i].frame & {FRAME_W{first_vec[i]}});
        end
    end

    assign result.hit   = |match_vec;
    assign result.first = first_vec;
    assign result.frame = frame_sel;

endmodule

// File: src/fifo_tlb.sv
// Top level of the fully associative translation buffer with FIFO replacement.
// Depends on ftlb_pkg and ftlb_match.
//
// Usage:
//   Slave stream s_*: one operation per transfer; s_tuser carries the opcode
//   (lookup, insert, invalidate), s_tdata the process, page and frame.
//   Master stream m_*: one result per operation, in order: hit, frame,
//   evicted and removed flags, and the running hit and miss totals.
//   APB port: register 0 at 0x0 is the enable bit, register 1 at 0x4 the
//   size limit (0 acts as 1, above the slot count acts as the slot count).
//   The result passes from the input register to the result register and is
//   held there until it transfers. Throughput is one operation per cycle
//   while m_tready is high: every slot is compared and the list is compacted
//   combinationally between the input register and the result register.
//   Reset empties the buffer, clears both counters, disables it and sets the
//   size to 16; slot contents are not cleared. When m_tready is low the
//   result register holds, the input register fills, and s_tready drops.
//   Configuration must be written with no operation in flight; it is not enforced.
module fifo_tlb (
    input  logic        aclk,
    input  logic        aresetn,
    // slave stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // process_id[15:0], page_number[31:16], frame_in[43:32]
    input  logic [1:0]  s_tuser,   // operation[1:0]
    // master stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // hit[0], frame_out[12:1], evicted[13], removed[14],
                                   // hit_total[46:15], miss_total[78:47]
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ftlb_pkg::*;

    // configuration
    logic              enable_reg;
    logic [SIZE_W-1:0] size_reg;

    // input register
    logic               in_valid_reg;
    op_t                in_op_reg;
    logic [PID_W-1:0]   in_pid_reg;
    logic [PAGE_W-1:0]  in_page_reg;
    logic [FRAME_W-1:0] in_frame_reg;

    // buffer state
    entry_t            entry_reg  [TLB_ENTRIES];
    entry_t            entry_next [TLB_ENTRIES];
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CTR_W-1:0]  hits_reg, hits_next;
    logic [CTR_W-1:0]  misses_reg, misses_next;

    // result register
    logic               m_valid_reg;
    logic               hit_reg, hit_next;
    logic [FRAME_W-1:0] frame_reg, frame_next;
    logic               evicted_reg, evicted_next;
    logic               removed_reg, removed_next;

    match_t             srch;
    logic               advance;
    logic [CNT_W-1:0]   eff_size;
    logic               do_shift, do_append;
    logic [TLB_ENTRIES-1:0] shift_mask;
    logic [IDX_W-1:0]   wr_idx;
    logic [CNT_W-1:0]   cnt_dec;
    logic               frame_ok;

    assign advance  = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign pready = 1'b1;

    always_comb begin
        unique case (paddr[2])
            REG_ENABLE: prdata = {31'd0, enable_reg};
            REG_SIZE:   prdata = {{(32 - SIZE_W){1'b0}}, size_reg};
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg <= 1'b0;
            size_reg   <= SIZE_W'(16);
        end else if (psel && penable && pwrite && pready) begin
            unique case (paddr[2])
                REG_ENABLE: enable_reg <= pwdata[0];
                REG_SIZE:   size_reg   <= pwdata[SIZE_W-1:0];
                default:    ;
            endcase
        end
    end

    ftlb_match u_match (
        .entries (entry_reg),
        .count   (count_reg),
        .pid     (in_pid_reg),
        .page    (in_page_reg),
        .result  (srch)
    );

    always_comb begin
        if (size_reg == '0)
            eff_size = CNT_W'(1);
        else if (32'(size_reg) > TLB_ENTRIES)
            eff_size = CNT_W'(TLB_ENTRIES);
        else
            eff_size = CNT_W'(size_reg);
    end

    assign frame_ok = 32'(in_frame_reg) < FRAME_COUNT;
    assign cnt_dec  = count_reg - CNT_W'(1);

    always_comb begin
        hit_next     = 1'b0;
        frame_next   = '0;
        evicted_next = 1'b0;
        removed_next = 1'b0;
        hits_next    = hits_reg;
        misses_next  = misses_reg;
        count_next   = count_reg;
        do_shift     = 1'b0;
        do_append    = 1'b0;
        shift_mask   = '0;
        wr_idx       = count_reg[IDX_W-1:0];

        unique case (in_op_reg)
            OP_LOOKUP: begin
                if (enable_reg) begin
                    if (srch.hit) begin
                        hit_next   = 1'b1;
                        frame_next = srch.frame;
                        hits_next  = hits_reg + CTR_W'(1);
                    end else begin
                        misses_next = misses_reg + CTR_W'(1);
                    end
                end
            end
            OP_INSERT: begin
                if (enable_reg && frame_ok) begin
                    do_append = 1'b1;
                    if (count_reg >= eff_size) begin
                        // drop oldest, shift all down, append at the old top
                        evicted_next = 1'b1;
                        do_shift     = 1'b1;
                        shift_mask   = '1;
                        wr_idx       = cnt_dec[IDX_W-1:0];
                    end else begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
            end
            OP_INVALIDATE: begin
                if (srch.hit) begin
                    removed_next = 1'b1;
                    do_shift     = 1'b1;
                    // slots at and above the match move down
                    shift_mask   = ~(srch.first - TLB_ENTRIES'(1));
                    count_next   = cnt_dec;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        for (int i = 0; i < TLB_ENTRIES; i++) begin
            entry_next[i] = entry_reg[i];
            if (do_shift && shift_mask[i] && (i < TLB_ENTRIES - 1))
                entry_next[i] = entry_reg[(i + 1) % TLB_ENTRIES];
            if (do_append && (wr_idx == IDX_W'(i))) begin
                entry_next[i].pid   = in_pid_reg;
                entry_next[i].page  = in_page_reg;
                entry_next[i].frame = in_frame_reg;
            end
        end
    end

    // slot contents carry no reset; only slots below the count are searched
    always_ff @(posedge aclk) begin
        if (advance) begin
            for (int i = 0; i < TLB_ENTRIES; i++) begin
                entry_reg[i] <= entry_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            count_reg    <= '0;
            hits_reg     <= '0;
            misses_reg   <= '0;
        end else begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance) begin
                m_valid_reg <= 1'b1;
                count_reg   <= count_next;
                hits_reg    <= hits_next;
                misses_reg  <= misses_next;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_op_reg    <= op_t'(s_tuser);
            in_pid_reg   <= s_tdata[15:0];
            in_page_reg  <= s_tdata[31:16];
            in_frame_reg <= s_tdata[43:32];
        end
        if (advance) begin
            hit_reg     <= hit_next;
            frame_reg   <= frame_next;
            evicted_reg <= evicted_next;
            removed_reg <= removed_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, misses_reg, hits_reg, removed_reg, evicted_reg,
                       frame_reg, hit_reg};

endmodule
